[rtl/owrs_pkg.sv]
// Package: command codes, result layout and constants of the ROM search unit.
`timescale 1ns / 1ps

package owrs_pkg;

    // Number of ROM bits walked in one pass, and the first position past the family byte.
    localparam int unsigned ROM_BITS     = 64;
    localparam int unsigned FAMILY_LIMIT = 9;

    // Widths of the stream payloads.
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 72;
    localparam int unsigned M_TUSER_W = 2;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BIT   = 2'd1,
        CMD_RESET = 2'd2
    } t_cmd;

    typedef struct packed {
        logic        write_valid;
        logic        write_value;
        logic        send_search_cmd;
        logic        pass_done;
        logic        device_found;
        logic [63:0] rom_code;
        logic [3:0]  family_disc;
    } t_result;

endpackage

[rtl/onewire_rom_search_unit.sv]
// Top level: 1-Wire ROM search decision engine with a two-entry output buffer.
`timescale 1ns / 1ps
//
// Usage
//   Slave channel (s_axis_*): one item per command. s_axis_tuser carries the
//   command (0 start a pass, 1 bit pair read, 2 reset search state); tdata
//   carries the presence flag and the true/complement bits read from the bus.
//   Master channel (m_axis_*): exactly one result item per accepted item, in
//   order. tlast marks the item that ended the search attempt (pass_done),
//   tuser flags a direction bit to write and a request to send the search ROM
//   command, tdata holds the direction bit, the found flag, the ROM register
//   and the family discrepancy position.
// Result path and flow
//   The decision and the state update happen at the accepting edge; the result
//   is registered into the main output entry, or into the skid entry while the
//   main entry is held. One item per cycle is accepted while the skid entry is empty.
// Reset
//   i_rst_n low clears the ROM register, discrepancy state, pass state and
//   both output buffer entries at the next rising edge.
// Stall
//   When the receiver holds m_axis_tready low, one more item is taken into
//   the skid entry; after that s_axis_tready drops until the receiver takes
//   the waiting result.
//
module onewire_rom_search_unit
    import owrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [0] presence, [1] id_bit, [2] comp_bit, [7:3] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] command
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] write_value, [1] device_found, [65:2] rom_code, [69:66] family_disc, [71:70] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] write_valid, [1] send_search_cmd
    output logic [M_TUSER_W-1:0] m_axis_tuser,
    // pass_done
    output logic                 m_axis_tlast
);

    // Search state.
    logic [63:0] r_rom,        n_rom;
    logic [6:0]  r_last_disc,  n_last_disc;
    logic [3:0]  r_family,     n_family;
    logic        r_last_dev,   n_last_dev;
    logic [6:0]  r_bit_idx,    n_bit_idx;
    logic [6:0]  r_last_zero,  n_last_zero;
    logic        r_active,     n_active;

    // Output buffer: main entry and skid entry.
    t_result     r_out, r_skid, n_res;
    logic        r_out_valid, r_skid_valid;

    logic        accept, out_take;
    t_cmd        cmd;
    logic        pres, idb, cmpb;
    logic [5:0]  sh;
    logic        dir;
    logic [7:0]  low_byte;

    assign cmd  = t_cmd'(s_axis_tuser[1:0]);
    assign pres = s_axis_tdata[0];
    assign idb  = s_axis_tdata[1];
    assign cmpb = s_axis_tdata[2];

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;

    assign sh = 6'(r_bit_idx - 7'd1);

    // Decision for one item and the state it leaves.
    always_comb begin
        n_rom       = r_rom;
        n_last_disc = r_last_disc;
        n_family    = r_family;
        n_last_dev  = r_last_dev;
        n_bit_idx   = r_bit_idx;
        n_last_zero = r_last_zero;
        n_active    = r_active;
        n_res       = '0;
        dir         = 1'b0;
        low_byte    = '0;

        case (cmd)
            CMD_RESET: begin
                n_rom       = '0;
                n_last_disc = '0;
                n_family    = '0;
                n_last_dev  = 1'b0;
                n_bit_idx   = 7'd1;
                n_last_zero = '0;
                n_active    = 1'b0;
            end
            CMD_START: begin
                n_bit_idx   = 7'd1;
                n_last_zero = '0;
                if (r_last_dev || !pres) begin
                    // Enumeration finished or nobody on the bus: fail and restart.
                    n_active          = 1'b0;
                    n_last_disc       = '0;
                    n_family          = '0;
                    n_last_dev        = 1'b0;
                    n_res.pass_done   = 1'b1;
                end else begin
                    n_active              = 1'b1;
                    n_res.send_search_cmd = 1'b1;
                end
            end
            CMD_BIT: begin
                if (r_active) begin
                    if (idb && cmpb) begin
                        // No device answered: abort the pass.
                        n_active        = 1'b0;
                        n_bit_idx       = 7'd1;
                        n_last_disc     = '0;
                        n_family        = '0;
                        n_last_dev      = 1'b0;
                        n_res.pass_done = 1'b1;
                    end else begin
                        if (idb != cmpb) begin
                            dir = idb;
                        end else begin
                            // Discrepancy: follow the previous path below the
                            // last branch point, take 1 at it, 0 beyond it.
                            if (r_bit_idx < r_last_disc) begin
                                dir = r_rom[sh];
                            end else begin
                                dir = (r_bit_idx == r_last_disc);
                            end
                            if (!dir) begin
                                n_last_zero = r_bit_idx;
                                if (r_bit_idx < 7'(FAMILY_LIMIT)) begin
                                    n_family = r_bit_idx[3:0];
                                end
                            end
                        end
                        n_rom[sh]         = dir;
                        n_res.write_valid = 1'b1;
                        n_res.write_value = dir;
                        n_bit_idx         = r_bit_idx + 7'd1;
                        if (r_bit_idx >= 7'(ROM_BITS)) begin
                            // Last ROM bit: close the pass and record the branch point.
                            n_active           = 1'b0;
                            n_bit_idx          = 7'd1;
                            n_res.pass_done    = 1'b1;
                            n_last_disc        = n_last_zero;
                            n_last_dev         = (n_last_zero == '0) ? 1'b1 : r_last_dev;
                            n_res.device_found = 1'b1;
                            low_byte           = n_rom[7:0];
                            if (low_byte == '0) begin
                                // Zero family byte counts as a failed search.
                                n_last_disc        = '0;
                                n_family           = '0;
                                n_last_dev         = 1'b0;
                                n_res.device_found = 1'b0;
                            end
                        end
                    end
                end
            end
            default: begin
                // Unused command code: leave the state alone and give a result with no flags set.
            end
        endcase

        n_res.rom_code    = n_rom;
        n_res.family_disc = n_family;
    end

    // Search state register: update on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom       <= '0;
            r_last_disc <= '0;
            r_family    <= '0;
            r_last_dev  <= 1'b0;
            r_bit_idx   <= 7'd1;
            r_last_zero <= '0;
            r_active    <= 1'b0;
        end else if (accept) begin
            r_rom       <= n_rom;
            r_last_disc <= n_last_disc;
            r_family    <= n_family;
            r_last_dev  <= n_last_dev;
            r_bit_idx   <= n_bit_idx;
            r_last_zero <= n_last_zero;
            r_active    <= n_active;
        end
    end

    // Output buffer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output buffer payload.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (r_out_valid && !out_take) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.pass_done;
    assign m_axis_tuser  = {r_out.send_search_cmd, r_out.write_valid};
    assign m_axis_tdata  = {2'b00, r_out.family_disc, r_out.rom_code,
                            r_out.device_found, r_out.write_value};

endmodule

[rtl/owrs_checker.sv]
// Checker on the ports of the ROM search unit, with its bind statement.
`timescale 1ns / 1ps

module owrs_checker
    import owrs_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser,
    input logic                 m_axis_tlast
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A found device is only reported on the item that ends the attempt.
    a_found_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tlast)
        else $error("device_found without pass_done");

    // Starting a pass neither writes a bit nor ends the attempt.
    a_start_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && !m_axis_tlast)
        else $error("send_search_cmd with other flags");

    // A direction bit of one is only shown with write_valid.
    a_value_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tuser[0])
        else $error("write_value without write_valid");

    // Reset empties the output buffer.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output not empty after reset");

endmodule

bind onewire_rom_search_unit owrs_checker u_owrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[dv/testbench.sv]
// Testbench for the ROM search unit: directed and random items against an in-bench predictor.
`timescale 1ns / 1ps

module testbench;
    import owrs_pkg::*;

    // Code the block must ignore; it has no member in the command enum.
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 60;
    localparam int         MAX_DEVICES  = 4;
    localparam int         PRINT_LIMIT  = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // [0] presence, [1] id_bit, [2] comp_bit, [7:3] zero
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // [1:0] command
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [0] write_value, [1] device_found, [65:2] rom_code, [69:66] family_disc, [71:70] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // [0] write_valid, [1] send_search_cmd
    logic [M_TUSER_W-1:0] m_axis_tuser;
    // pass_done
    logic                 m_axis_tlast;

    onewire_rom_search_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Search state as the block should hold it.
    logic [63:0] srch_rom;
    logic [6:0]  srch_last_disc;
    logic [3:0]  srch_family;
    logic        srch_last_dev;
    logic [6:0]  srch_bit_pos;
    logic [6:0]  srch_last_zero;
    logic        srch_active;

    t_result     pending_results[$];
    t_result     last_prediction;
    int          error_count = 0;
    int          live_items  = 0;   // accepted items that the block does not ignore
    int          idle_pct    = 25;  // chance in a hundred, at each draw, that either side idles

    // Simulated devices on the wire, walked by the search passes.
    logic [63:0] bus_rom[MAX_DEVICES];
    int          bus_devices  = 0;
    logic        bus_presence = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic void forget_discrepancy();
        srch_last_disc = '0;
        srch_family    = '0;
        srch_last_dev  = 1'b0;
    endfunction

    function automatic void reset_search_state();
        srch_rom       = '0;
        forget_discrepancy();
        srch_bit_pos   = 7'd1;
        srch_last_zero = '0;
        srch_active    = 1'b0;
    endfunction

    // Advance the search state by one item and return the result it must produce.
    function automatic t_result next_search_result(input logic [1:0] cmd, input logic pres,
                                                   input logic idb, input logic cmpb);
        t_result    r;
        logic [6:0] pos;
        logic [5:0] sh;
        logic       dir;
        r = '0;
        case (cmd)
            CMD_RESET: begin
                reset_search_state();
            end
            CMD_START: begin
                srch_bit_pos   = 7'd1;
                srch_last_zero = '0;
                // Fail on a silent bus or once the last device was already reported.
                if (srch_last_dev || !pres) begin
                    srch_active = 1'b0;
                    forget_discrepancy();
                    r.pass_done = 1'b1;
                end else begin
                    srch_active       = 1'b1;
                    r.send_search_cmd = 1'b1;
                end
            end
            CMD_BIT: begin
                if (srch_active && idb && cmpb) begin
                    // Nobody answered: abort the pass.
                    srch_active  = 1'b0;
                    srch_bit_pos = 7'd1;
                    forget_discrepancy();
                    r.pass_done  = 1'b1;
                end else if (srch_active) begin
                    pos = srch_bit_pos;
                    sh  = 6'(pos - 7'd1);
                    if (idb != cmpb) begin
                        dir = idb;
                    end else begin
                        // Discrepancy: follow the old path below the last fork, take 1 at it.
                        if (pos < srch_last_disc)
                            dir = srch_rom[sh];
                        else
                            dir = (pos == srch_last_disc);
                        if (!dir) begin
                            srch_last_zero = pos;
                            if (pos < FAMILY_LIMIT)
                                srch_family = pos[3:0];
                        end
                    end
                    srch_rom[sh]  = dir;
                    r.write_valid = 1'b1;
                    r.write_value = dir;
                    srch_bit_pos  = pos + 7'd1;
                    if (srch_bit_pos > ROM_BITS) begin
                        srch_active    = 1'b0;
                        srch_bit_pos   = 7'd1;
                        r.pass_done    = 1'b1;
                        srch_last_disc = srch_last_zero;
                        if (srch_last_disc == '0)
                            srch_last_dev = 1'b1;
                        r.device_found = 1'b1;
                        // A zero family byte is no device at all.
                        if (srch_rom[7:0] == 8'd0) begin
                            forget_discrepancy();
                            r.device_found = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.rom_code    = srch_rom;
        r.family_disc = srch_family;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (error_count < PRINT_LIMIT)
            $display("testbench: %0t ns %s: expected %0h, got %0h", $time, what, want, got);
        error_count++;
    endtask

    // Offer one item, hold it until taken, then record what it must produce.
    task automatic send_item(input logic [1:0] cmd, input logic pres, input logic idb,
                             input logic cmpb);
        bit ignored;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'b0, cmpb, idb, pres};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        ignored = (cmd == CMD_UNUSED) || (cmd == CMD_BIT && !srch_active);
        last_prediction = next_search_result(cmd, pres, idb, cmpb);
        pending_results.push_back(last_prediction);
        if (!ignored)
            live_items++;
    endtask

    // Hold the sender until every pending result has come back.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // One pass over the simulated wire: the true and complement bits are the
    // wired-AND of the devices still in the race, and devices whose bit differs
    // from the chosen direction drop out. Stop early at abort_at when nonzero.
    task automatic run_search_pass(input int abort_at, output bit failed);
        bit   alive[MAX_DEVICES];
        logic idb;
        logic cmpb;
        failed = 1'b0;
        send_item(CMD_START, bus_presence, 1'($urandom), 1'($urandom));
        if (last_prediction.pass_done) begin
            failed = 1'b1;
            return;
        end
        for (int d = 0; d < MAX_DEVICES; d++)
            alive[d] = (d < bus_devices);
        for (int pos = 1; pos <= 64; pos++) begin
            if (pos == abort_at)
                return;
            idb  = 1'b1;
            cmpb = 1'b1;
            for (int d = 0; d < MAX_DEVICES; d++) begin
                if (alive[d]) begin
                    if (bus_rom[d][pos-1])
                        cmpb = 1'b0;
                    else
                        idb = 1'b0;
                end
            end
            send_item(CMD_BIT, 1'($urandom), idb, cmpb);
            if (last_prediction.pass_done && !last_prediction.device_found) begin
                failed = 1'b1;
                return;
            end
            for (int d = 0; d < MAX_DEVICES; d++)
                if (alive[d] && bus_rom[d][pos-1] != last_prediction.write_value)
                    alive[d] = 0;
        end
    endtask

    // Repeat passes until a start or a pass fails, as a host walks the whole tree.
    task automatic enumerate_bus();
        bit failed;
        int passes;
        passes = 0;
        do begin
            run_search_pass(0, failed);
            passes++;
        end while (!failed && passes < bus_devices + 3);
    endtask

    // Fill the wire with a few related devices, with the odd empty or odd bus.
    function automatic void make_random_bus();
        logic [63:0] base;
        int          pick;
        base = {$urandom, $urandom};
        if (base[7:0] == 8'd0)
            base[0] = 1'b1;
        bus_devices  = $urandom_range(1, 3);
        bus_presence = 1'b1;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            bus_devices  = 0;
            bus_presence = 1'b0;
        end else if (pick == 1) begin
            // Presence seen but nobody answers the bit pairs.
            bus_devices = 0;
        end
        for (int d = 0; d < bus_devices; d++) begin
            bus_rom[d] = base;
            if (d > 0)
                bus_rom[d] = base ^ (64'd1 << $urandom_range(0, 63))
                                  ^ (64'd1 << $urandom_range(8, 63));
            if (pick == 2)
                bus_rom[d][7:0] = 8'd0;
            else if (pick == 3)
                bus_rom[d] = {$urandom, $urandom};
        end
    endfunction

    // Short walk through every command and each corner of the decision logic.
    task automatic test_command_cases();
        send_item(CMD_BIT,    1'b1, 1'b0, 1'b1);  // pair with no pass: ignored
        send_item(CMD_UNUSED, 1'b1, 1'b1, 1'b1);  // unused code: ignored
        send_item(CMD_START,  1'b0, 1'b1, 1'b0);  // no presence: fail
        send_item(CMD_START,  1'b1, 1'b0, 1'b0);
        send_item(CMD_BIT,    1'b0, 1'b0, 1'b1);  // all devices read 0
        send_item(CMD_BIT,    1'b1, 1'b1, 1'b0);  // all devices read 1
        send_item(CMD_BIT,    1'b0, 1'b0, 1'b0);  // fork inside the family byte
        send_item(CMD_START,  1'b1, 1'b1, 1'b1);  // restart while a pass runs
        send_item(CMD_BIT,    1'b0, 1'b0, 1'b0);
        send_item(CMD_BIT,    1'b1, 1'b1, 1'b1);  // nobody answers: abort
        send_item(CMD_BIT,    1'b0, 1'b1, 1'b0);  // after the abort: ignored
        send_item(CMD_START,  1'b1, 1'b0, 1'b0);
        send_item(CMD_BIT,    1'b1, 1'b1, 1'b0);
        send_item(CMD_RESET,  1'b1, 1'b1, 1'b1);  // clear in the middle of a pass
        send_item(CMD_BIT,    1'b1, 1'b0, 1'b1);
        send_item(CMD_UNUSED, 1'b0, 1'b0, 1'b0);
        send_item(CMD_RESET,  1'b0, 1'b0, 1'b0);
    endtask

    // Full enumerations of fixed populations: extremes of the ROM and forks at both ends.
    task automatic test_enumeration();
        // One device of all ones; the start after it must report the end.
        bus_presence = 1'b1;
        bus_devices  = 1;
        bus_rom[0]   = 64'hFFFF_FFFF_FFFF_FFFF;
        enumerate_bus();
        // One device with a zero family byte.
        bus_rom[0]   = 64'hA5A5_0F0F_3C3C_5A00;
        enumerate_bus();
        // Three devices: a fork in the family byte and one at the last bit.
        // Run this one with no idling on either side.
        idle_pct     = 0;
        bus_devices  = 3;
        bus_rom[0]   = 64'h0123_4567_89AB_CD28;
        bus_rom[1]   = 64'h8123_4567_89AB_CD28;
        bus_rom[2]   = 64'h0123_4567_89AB_CD2C;
        enumerate_bus();
        idle_pct     = 25;
        // All zeros against all ones: the zero path wins first and fails.
        bus_devices  = 2;
        bus_rom[0]   = 64'h0;
        bus_rom[1]   = 64'hFFFF_FFFF_FFFF_FFFF;
        enumerate_bus();
    endtask

    // Mostly whole enumerations of random populations, with cut passes and noise.
    task automatic test_random_traffic();
        int start_count;
        int pick;
        bit failed;
        start_count = live_items;
        while (live_items - start_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                make_random_bus();
                enumerate_bus();
            end else if (pick < 70) begin
                run_search_pass($urandom_range(1, 64), failed);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                              1'($urandom));
            end
        end
    endtask

    // Receiver: stall at random as often as the sender idles.
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);

    // Compare every taken result against the oldest pending one.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 64'd0, 64'd1);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser[0] !== want.write_valid)
                    report_mismatch("write_valid", want.write_valid, m_axis_tuser[0]);
                if (m_axis_tdata[0] !== want.write_value)
                    report_mismatch("write_value", want.write_value, m_axis_tdata[0]);
                if (m_axis_tuser[1] !== want.send_search_cmd)
                    report_mismatch("send_search_cmd", want.send_search_cmd, m_axis_tuser[1]);
                if (m_axis_tlast !== want.pass_done)
                    report_mismatch("pass_done", want.pass_done, m_axis_tlast);
                if (m_axis_tdata[1] !== want.device_found)
                    report_mismatch("device_found", want.device_found, m_axis_tdata[1]);
                if (m_axis_tdata[65:2] !== want.rom_code)
                    report_mismatch("rom_code", want.rom_code, m_axis_tdata[65:2]);
                if (m_axis_tdata[69:66] !== want.family_disc)
                    report_mismatch("family_disc", want.family_disc, m_axis_tdata[69:66]);
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_START;
        reset_search_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_command_cases();
        wait_results_drained();
        test_enumeration();
        wait_results_drained();
        test_random_traffic();
        wait_results_drained();

        // Let a stray late result show up before the verdict.
        repeat (4) @(posedge i_clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
